// File: hdl/btlv_pkg.sv
// Shared types and constants of the BER TLV primitive decoder.
package btlv_pkg;

    localparam int MAX_LENGTH_BYTES  = 4;
    localparam int MAX_INTEGER_BYTES = 4;
    localparam int LBL_W             = $clog2(MAX_LENGTH_BYTES + 1);
    localparam int VBC_W             = $clog2(MAX_INTEGER_BYTES + 1);

    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_INTEGER = 3'd1,
        KIND_OID_ARC = 3'd2,
        KIND_RAW     = 3'd3,
        KIND_EOC     = 3'd4,
        KIND_ERROR   = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_INT_LONG    = 3'd1,
        ERR_LENGTH_LONG = 3'd2,
        ERR_TAG_LONG    = 3'd3,
        ERR_EMPTY_OID   = 3'd4
    } t_err;

    localparam logic [1:0] REG_INTEGER_SIGNED = 2'd0;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  tag_class;
        logic        constructed;
        logic [31:0] tag_number;
        logic        definite;
        logic [31:0] content_length;
        logic [31:0] value;
        logic        last;
        t_err        error_code;
    } t_result;

endpackage

// File: hdl/btlv_rq.sv
// Result queue: takes up to two results a cycle, hands out one a cycle unless stalled.
module btlv_rq
    import btlv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_result    i_res0,
    input  t_result    i_res1,
    output logic       o_space2,
    output logic       o_valid,
    input  logic       i_stall,
    output t_result    o_res
);

    t_result              r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0]     r_wp;
    logic [RQ_AW-1:0]     r_rp;
    logic [RQ_AW:0]       r_cnt;
    logic                 pop;
    logic [RQ_AW-1:0]     wp1;

    assign o_valid  = (r_cnt != '0);
    assign o_res    = r_mem[r_rp];
    assign pop      = o_valid && !i_stall;
    assign o_space2 = (r_cnt <= (RQ_AW + 1)'(RQ_DEPTH - 2));
    assign wp1      = r_wp + RQ_AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + RQ_AW'(i_push_cnt);
            r_rp  <= r_rp + RQ_AW'(pop);
            r_cnt <= r_cnt + (RQ_AW + 1)'(i_push_cnt) - (RQ_AW + 1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wp1] <= i_res1;
        end
    end

endmodule

// File: hdl/btlv_step.sv
// Decoder state and the per-octet update that yields up to two results.
module btlv_step
    import btlv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic [7:0] i_byte,
    input  logic       i_restart,
    input  logic       i_int_signed,
    output logic [1:0] o_res_cnt,
    output t_result    o_res0,
    output t_result    o_res1
);

    typedef enum logic [2:0] {
        PH_ID   = 3'd0,
        PH_TAG  = 3'd1,
        PH_LEN0 = 3'd2,
        PH_LENX = 3'd3,
        PH_BODY = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        CT_RAW  = 2'd0,
        CT_INT  = 2'd1,
        CT_OID  = 2'd2,
        CT_SKIP = 2'd3
    } t_ctype;

    t_phase            r_phase, n_phase, ph;
    logic [1:0]        r_class, n_class;
    logic              r_cons, n_cons;
    logic [31:0]       r_tag, n_tag;
    logic [2:0]        r_tbc, n_tbc;
    logic [31:0]       r_length, n_length;
    logic [LBL_W-1:0]  r_lbl, n_lbl;
    logic [31:0]       r_remaining, n_remaining;
    logic [31:0]       r_acc, n_acc;
    logic [VBC_W-1:0]  r_vbc, n_vbc;
    t_ctype            r_ctype, n_ctype;
    logic              r_first, n_first;

    logic [31:0]       cr_dec;
    logic              done;
    logic [31:0]       oid_s;
    logic              int_counts;
    logic              hdr, hdr_def, uni;

    t_kind             k0, k1;
    logic              d0, d1, l0, l1;
    logic [31:0]       v0, v1;
    t_err              e0, e1;

    assign cr_dec     = r_remaining - 32'd1;
    assign done       = (cr_dec == 32'd0);
    assign oid_s      = {r_acc[24:0], i_byte[6:0]};
    assign int_counts = i_int_signed || !(r_first && i_byte == 8'd0);

    always_comb begin
        n_phase     = r_phase;
        n_class     = r_class;
        n_cons      = r_cons;
        n_tag       = r_tag;
        n_tbc       = r_tbc;
        n_length    = r_length;
        n_lbl       = r_lbl;
        n_remaining = r_remaining;
        n_acc       = r_acc;
        n_vbc       = r_vbc;
        n_ctype     = r_ctype;
        n_first     = r_first;
        o_res_cnt   = 2'd0;
        k0 = KIND_HEADER; d0 = 1'b0; v0 = '0; l0 = 1'b0; e0 = ERR_NONE;
        k1 = KIND_HEADER; d1 = 1'b0; v1 = '0; l1 = 1'b0; e1 = ERR_NONE;
        hdr     = 1'b0;
        hdr_def = 1'b0;
        uni     = 1'b0;
        ph      = i_restart ? PH_ID : r_phase;

        unique case (ph)
            PH_ID: begin
                n_class  = i_byte[7:6];
                n_cons   = i_byte[5];
                n_length = '0;
                n_lbl    = '0;
                n_tbc    = '0;
                if (i_byte[4:0] == 5'h1F) begin
                    n_tag   = '0;
                    n_phase = PH_TAG;
                end else begin
                    n_tag   = {27'd0, i_byte[4:0]};
                    n_phase = PH_LEN0;
                end
            end
            PH_TAG: begin
                if (r_tag[31:25] != 7'd0) begin
                    n_phase   = PH_ID;
                    o_res_cnt = 2'd1;
                    k0 = KIND_ERROR; l0 = 1'b1; e0 = ERR_TAG_LONG;
                end else begin
                    n_tag = {r_tag[24:0], i_byte[6:0]};
                    if (r_tbc != 3'd7) begin
                        n_tbc = r_tbc + 3'd1;
                    end
                    if (!i_byte[7]) begin
                        n_phase = PH_LEN0;
                    end
                end
            end
            PH_LEN0: begin
                if (i_byte == 8'd0 && r_class == 2'd0 && !r_cons &&
                    r_tag == 32'd0 && r_tbc == 3'd0) begin
                    n_phase   = PH_ID;
                    o_res_cnt = 2'd1;
                    k0 = KIND_EOC; d0 = 1'b1; l0 = 1'b1;
                end else if (i_byte == 8'h80) begin
                    hdr = 1'b1;
                end else if (!i_byte[7]) begin
                    n_length = {24'd0, i_byte};
                    hdr      = 1'b1;
                    hdr_def  = 1'b1;
                end else if (i_byte[6:0] > 7'(MAX_LENGTH_BYTES)) begin
                    n_phase   = PH_ID;
                    o_res_cnt = 2'd1;
                    k0 = KIND_ERROR; l0 = 1'b1; e0 = ERR_LENGTH_LONG;
                end else begin
                    n_lbl   = LBL_W'(i_byte[6:0]);
                    n_phase = PH_LENX;
                end
            end
            PH_LENX: begin
                if (r_length[31:24] != 8'd0) begin
                    n_phase   = PH_ID;
                    o_res_cnt = 2'd1;
                    k0 = KIND_ERROR; l0 = 1'b1; e0 = ERR_LENGTH_LONG;
                end else begin
                    n_length = {r_length[23:0], i_byte};
                    if (r_lbl > LBL_W'(1)) begin
                        n_lbl = r_lbl - LBL_W'(1);
                    end else begin
                        n_lbl   = '0;
                        hdr     = 1'b1;
                        hdr_def = 1'b1;
                    end
                end
            end
            PH_BODY: begin
                n_remaining = cr_dec;
                if (done) begin
                    n_phase = PH_ID;
                end
                unique case (r_ctype)
                    CT_RAW: begin
                        o_res_cnt = 2'd1;
                        k0 = KIND_RAW; d0 = 1'b1; v0 = {24'd0, i_byte}; l0 = done;
                    end
                    CT_SKIP: begin
                    end
                    CT_INT: begin
                        if (int_counts && r_vbc >= VBC_W'(MAX_INTEGER_BYTES)) begin
                            n_ctype   = CT_SKIP;
                            o_res_cnt = 2'd1;
                            k0 = KIND_ERROR; d0 = 1'b1; l0 = 1'b1; e0 = ERR_INT_LONG;
                        end else begin
                            if (int_counts) begin
                                n_vbc = r_vbc + VBC_W'(1);
                            end
                            if (i_int_signed && r_first) begin
                                n_acc = {{24{i_byte[7]}}, i_byte};
                            end else begin
                                n_acc = {r_acc[23:0], i_byte};
                            end
                            n_first = 1'b0;
                            if (done) begin
                                o_res_cnt = 2'd1;
                                k0 = KIND_INTEGER; d0 = 1'b1; v0 = n_acc; l0 = 1'b1;
                            end
                        end
                    end
                    CT_OID: begin
                        n_acc = oid_s;
                        if (!i_byte[7] || done) begin
                            n_acc = '0;
                            if (r_first) begin
                                // split the first subidentifier into two arcs
                                n_first   = 1'b0;
                                o_res_cnt = 2'd2;
                                k0 = KIND_OID_ARC; d0 = 1'b1;
                                k1 = KIND_OID_ARC; d1 = 1'b1; l1 = done;
                                if (oid_s < 32'd40) begin
                                    v0 = 32'd0; v1 = oid_s;
                                end else if (oid_s < 32'd80) begin
                                    v0 = 32'd1; v1 = oid_s - 32'd40;
                                end else begin
                                    v0 = 32'd2; v1 = oid_s - 32'd80;
                                end
                            end else begin
                                o_res_cnt = 2'd1;
                                k0 = KIND_OID_ARC; d0 = 1'b1; v0 = oid_s; l0 = done;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_phase = PH_ID;
            end
        endcase

        if (hdr) begin
            uni = (n_class == 2'd0) && !n_cons;
            if (!hdr_def) begin
                n_length = '0;
            end
            if (!hdr_def || n_cons || n_length == 32'd0) begin
                n_phase = PH_ID;
                k0 = KIND_HEADER; d0 = hdr_def;
                if (hdr_def && uni && n_tag == 32'd2) begin
                    o_res_cnt = 2'd2;
                    k1 = KIND_INTEGER; d1 = 1'b1; l1 = 1'b1;
                end else if (hdr_def && uni && n_tag == 32'd6) begin
                    o_res_cnt = 2'd2;
                    k1 = KIND_ERROR; d1 = 1'b1; l1 = 1'b1; e1 = ERR_EMPTY_OID;
                end else begin
                    o_res_cnt = 2'd1;
                    l0 = 1'b1;
                end
            end else begin
                n_remaining = n_length;
                n_phase     = PH_BODY;
                if (uni && n_tag == 32'd2) begin
                    n_ctype = CT_INT;
                end else if (uni && n_tag == 32'd6) begin
                    n_ctype = CT_OID;
                end else begin
                    n_ctype = CT_RAW;
                end
                n_acc     = '0;
                n_vbc     = '0;
                n_first   = 1'b1;
                o_res_cnt = 2'd1;
                k0 = KIND_HEADER; d0 = 1'b1;
            end
        end

        o_res0.kind           = k0;
        o_res0.tag_class      = n_class;
        o_res0.constructed    = n_cons;
        o_res0.tag_number     = n_tag;
        o_res0.definite       = d0;
        o_res0.content_length = d0 ? n_length : 32'd0;
        o_res0.value          = v0;
        o_res0.last           = l0;
        o_res0.error_code     = e0;

        o_res1.kind           = k1;
        o_res1.tag_class      = n_class;
        o_res1.constructed    = n_cons;
        o_res1.tag_number     = n_tag;
        o_res1.definite       = d1;
        o_res1.content_length = d1 ? n_length : 32'd0;
        o_res1.value          = v1;
        o_res1.last           = l1;
        o_res1.error_code     = e1;

        if (!i_advance) begin
            o_res_cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ID;
            r_class     <= '0;
            r_cons      <= 1'b0;
            r_tag       <= '0;
            r_tbc       <= '0;
            r_length    <= '0;
            r_lbl       <= '0;
            r_remaining <= '0;
            r_acc       <= '0;
            r_vbc       <= '0;
            r_ctype     <= CT_RAW;
            r_first     <= 1'b1;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_class     <= n_class;
            r_cons      <= n_cons;
            r_tag       <= n_tag;
            r_tbc       <= n_tbc;
            r_length    <= n_length;
            r_lbl       <= n_lbl;
            r_remaining <= n_remaining;
            r_acc       <= n_acc;
            r_vbc       <= n_vbc;
            r_ctype     <= n_ctype;
            r_first     <= n_first;
        end
    end

endmodule

// File: hdl/ber_tlv_primitive_decoder_core.sv
// Top level of the BER TLV primitive decoder: input register, APB register, result queue.
//
// One BER octet enters per transaction on the input channel (i_in_valid,
// o_in_stall, i_data_byte, i_restart); i_restart forces the octet to be
// taken as a first identifier octet. Each octet gives zero, one or two
// results (header, integer value, OID arc, raw byte, end of contents or
// error), each leaving as one transaction on the output channel
// (o_out_valid, i_out_stall and the o_ result fields).
// An accepted octet is captured in the input register, its update runs
// from there once the queue has room for two results, and its results
// are written into the result queue, from which they are offered.
// Throughput is one octet per cycle while results drain at least as fast;
// an octet that yields two results leaves as two output transactions.
// A four-entry result queue parts the two sides: the input register
// advances only while the queue has room for two results, so a stall on
// the output fills the queue and then stalls the input.
// Reset (synchronous, active low) empties the queue, returns the decoder to
// expecting an identifier octet and sets integer_signed to 1.
// integer_signed lies at APB address 0; the user must write it only while idle, as the block does not enforce this.
module ber_tlv_primitive_decoder_core
    import btlv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [1:0]  o_tag_class,
    output logic        o_constructed,
    output logic [31:0] o_tag_number,
    output logic        o_definite,
    output logic [31:0] o_content_length,
    output logic [31:0] o_value,
    output logic        o_last,
    output logic [2:0]  o_error_code
);

    logic        r_int_signed;
    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_restart;
    logic        q_space2;
    logic        advance;
    logic        in_take;
    logic [1:0]  res_cnt;
    t_result     res0, res1, head;

    assign pready  = 1'b1;
    assign prdata  = (paddr == REG_INTEGER_SIGNED[0:0]) ? {31'd0, r_int_signed} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_signed <= 1'b1;
        end else if (psel && penable && pwrite && pready &&
                     paddr == REG_INTEGER_SIGNED[0:0]) begin
            r_int_signed <= pwdata[0];
        end
    end

    assign advance    = r_in_valid && q_space2;
    assign o_in_stall = r_in_valid && !q_space2;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte    <= i_data_byte;
            r_restart <= i_restart;
        end
    end

    btlv_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_byte       (r_byte),
        .i_restart    (r_restart),
        .i_int_signed (r_int_signed),
        .o_res_cnt    (res_cnt),
        .o_res0       (res0),
        .o_res1       (res1)
    );

    btlv_rq u_rq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (res_cnt),
        .i_res0     (res0),
        .i_res1     (res1),
        .o_space2   (q_space2),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_res      (head)
    );

    assign o_kind           = head.kind;
    assign o_tag_class      = head.tag_class;
    assign o_constructed    = head.constructed;
    assign o_tag_number     = head.tag_number;
    assign o_definite       = head.definite;
    assign o_content_length = head.content_length;
    assign o_value          = head.value;
    assign o_last           = head.last;
    assign o_error_code     = head.error_code;

endmodule
